>>> sv/p2vb_pkg.sv
// Shared constants, types and helpers for the pixel-to-voxel binning block.
package p2vb_pkg;

   // Frame and field sizes
   localparam int MAX_BEAMS       = 1024;
   localparam int MAX_SAMPLES     = 1024;
   localparam int MAX_VOL_DIM_DEF = 512;
   localparam int NUM_COEF        = 12;
   localparam int NUM_ROWS        = 3;
   localparam int NUM_AXES        = 3;
   localparam int COEF_IDX_W      = 4;
   localparam int COEF_W          = 32;
   localparam int SPACE_W         = 32;
   localparam int PIX_IDX_W       = 10;
   localparam int VALUE_W         = 8;
   localparam int IDX_W           = 27;
   localparam int DIM_REG_W       = 10;
   localparam int Q_FRAC          = 16;
   localparam int HALF_Q16        = 32768;

   // Datapath widths
   localparam int POINT_W = PIX_IDX_W + SPACE_W;     // beam * spacing, unsigned Q26.16
   localparam int HI_W    = POINT_W - Q_FRAC;        // integer part of the point
   localparam int HP_W    = COEF_W + HI_W + 1;       // coef * point high part
   localparam int LP_W    = COEF_W + Q_FRAC + 1;     // coef * point low part
   localparam int TERM_W  = HP_W + 1;                // one pose product
   localparam int SUM_W   = TERM_W + 2;              // row sum with translation
   localparam int COORD_W = 47;                      // saturated Q30.16
   localparam int CHI_W   = COORD_W - Q_FRAC;        // coordinate integer part
   localparam int RHP_W   = CHI_W + SPACE_W + 1;     // integer part * reciprocal
   localparam int RLP_W   = Q_FRAC + SPACE_W;        // fraction part * reciprocal
   localparam int W_W     = RHP_W + 1;               // scaled coordinate

   // Item opcodes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   // Register indexes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_SPACING_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_SPACING_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_RECIP_X  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_RECIP_Y  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_RECIP_Z  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_VOL_DIM_X    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_VOL_DIM_Y    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_VOL_DIM_Z    = 3'd7;

   localparam logic [SPACE_W-1:0]   SPACING_ONE = 32'h0001_0000;
   localparam logic [DIM_REG_W-1:0] DIM_RESET   = 10'd256;

   typedef struct packed {
      logic [SPACE_W-1:0]   in_spacing_x;
      logic [SPACE_W-1:0]   in_spacing_y;
      logic [SPACE_W-1:0]   out_recip_x;
      logic [SPACE_W-1:0]   out_recip_y;
      logic [SPACE_W-1:0]   out_recip_z;
      logic [DIM_REG_W-1:0] vol_dim_x;
      logic [DIM_REG_W-1:0] vol_dim_y;
      logic [DIM_REG_W-1:0] vol_dim_z;
   } p2vb_cfg_type;

   localparam p2vb_cfg_type CFG_RESET = '{
      in_spacing_x: SPACING_ONE,
      in_spacing_y: SPACING_ONE,
      out_recip_x:  SPACING_ONE,
      out_recip_y:  SPACING_ONE,
      out_recip_z:  SPACING_ONE,
      vol_dim_x:    DIM_RESET,
      vol_dim_y:    DIM_RESET,
      vol_dim_z:    DIM_RESET
   };

   // Volume-space point handed from the transform to the quantizer
   typedef struct packed {
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic signed [COORD_W-1:0] cz;
      logic [VALUE_W-1:0]        value;
   } p2vb_point_type;

   // Pixel index times spacing, exact
   function automatic logic [POINT_W-1:0] scale_point(input logic [PIX_IDX_W-1:0] idx,
                                                      input logic [SPACE_W-1:0] sp);
      return POINT_W'(idx) * POINT_W'(sp);
   endfunction

   // Clip a row sum to the signed Q30.16 range
   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] s);
      logic [SUM_W-COORD_W:0] top;
      logic signed [COORD_W-1:0] r;
      top = s[SUM_W-1:COORD_W-1];
      if (&top || !(|top)) begin
         r = s[COORD_W-1:0];
      end else if (s[SUM_W-1]) begin
         r = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(COORD_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

>>> sv/p2vb_if.sv
// Valid/ready channel interfaces for pixel items and voxel results.
interface p2vb_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [3:0]  coef_index;
   logic signed [31:0] coef_value;
   logic [9:0]  beam;
   logic [9:0]  sample;
   logic [7:0]  pixel_value;
   logic        pixel_in_mask;

   modport source (output valid, op, coef_index, coef_value, beam, sample, pixel_value,
                   pixel_in_mask, input ready);
   modport sink (input valid, op, coef_index, coef_value, beam, sample, pixel_value,
                 pixel_in_mask, output ready);
endinterface

interface p2vb_rsp_if;
   logic        valid;
   logic        ready;
   logic [26:0] voxel_index;
   logic [7:0]  voxel_value;

   modport source (output valid, voxel_index, voxel_value, input ready);
   modport sink (input valid, voxel_index, voxel_value, output ready);
endinterface

>>> sv/p2vb_xform.sv
// Pose storage and the four-stage affine transform from pixel to volume millimetres.
module p2vb_xform
   import p2vb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  p2vb_cfg_type   cfg,
   p2vb_req_if.sink       req_chan,
   output logic           out_valid,
   input  logic           out_ready,
   output p2vb_point_type out_point
);

   // Pose matrix, row-major 3x4
   logic signed [COEF_W-1:0] pose_ff [NUM_COEF];
   logic signed [COEF_W-1:0] pose_in [NUM_COEF];

   logic accept;
   logic en1, en2, en3, en4;

   // Stage 1: point in millimetres
   logic               v1_ff, v1_in;
   logic [POINT_W-1:0] px1_ff, px1_in, py1_ff, py1_in;
   logic [VALUE_W-1:0] val1_ff;

   // Stage 2: split pose products
   logic                     v2_ff;
   logic signed [HP_W-1:0]   ah2_ff [NUM_ROWS], ah2_in [NUM_ROWS];
   logic signed [LP_W-1:0]   al2_ff [NUM_ROWS], al2_in [NUM_ROWS];
   logic signed [HP_W-1:0]   bh2_ff [NUM_ROWS], bh2_in [NUM_ROWS];
   logic signed [LP_W-1:0]   bl2_ff [NUM_ROWS], bl2_in [NUM_ROWS];
   logic signed [COEF_W-1:0] tr2_ff [NUM_ROWS];
   logic [VALUE_W-1:0]       val2_ff;

   // Stage 3: floored products
   logic                     v3_ff;
   logic signed [TERM_W-1:0] ta3_ff [NUM_ROWS], ta3_in [NUM_ROWS];
   logic signed [TERM_W-1:0] tb3_ff [NUM_ROWS], tb3_in [NUM_ROWS];
   logic signed [COEF_W-1:0] tr3_ff [NUM_ROWS];
   logic [VALUE_W-1:0]       val3_ff;

   // Stage 4: saturated row sums
   logic                      v4_ff;
   logic signed [COORD_W-1:0] c4_in [NUM_ROWS];
   p2vb_point_type            pt4_ff;

   // Per-stage advance, bubbles collapse
   assign en4 = !v4_ff || out_ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_chan.ready = en1;
   assign accept         = req_chan.valid && en1;

   // Coefficient load
   always_comb begin
      pose_in = pose_ff;
      if (accept && req_chan.op == OP_LOAD &&
          req_chan.coef_index < COEF_IDX_W'(NUM_COEF)) begin
         pose_in[req_chan.coef_index] = req_chan.coef_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEF; i++) begin
            pose_ff[i] <= '0;
         end
      end else begin
         pose_ff <= pose_in;
      end
   end

   // Stage 1 input: only masked-in pixels inside the frame travel on
   always_comb begin
      v1_in  = accept && req_chan.op == OP_PIXEL && req_chan.pixel_in_mask &&
               32'(req_chan.beam) < MAX_BEAMS && 32'(req_chan.sample) < MAX_SAMPLES;
      px1_in = scale_point(req_chan.beam, cfg.in_spacing_x);
      py1_in = scale_point(req_chan.sample, cfg.in_spacing_y);
   end

   // Stage 2 products; pose read here, after any earlier load has landed
   for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
      assign ah2_in[r] = HP_W'(pose_ff[4*r]) *
                         HP_W'($signed({1'b0, px1_ff[POINT_W-1:Q_FRAC]}));
      assign al2_in[r] = LP_W'(pose_ff[4*r]) *
                         LP_W'($signed({1'b0, px1_ff[Q_FRAC-1:0]}));
      assign bh2_in[r] = HP_W'(pose_ff[4*r+1]) *
                         HP_W'($signed({1'b0, py1_ff[POINT_W-1:Q_FRAC]}));
      assign bl2_in[r] = LP_W'(pose_ff[4*r+1]) *
                         LP_W'($signed({1'b0, py1_ff[Q_FRAC-1:0]}));
      assign ta3_in[r] = TERM_W'(ah2_ff[r]) + TERM_W'(al2_ff[r] >>> Q_FRAC);
      assign tb3_in[r] = TERM_W'(bh2_ff[r]) + TERM_W'(bl2_ff[r] >>> Q_FRAC);
      assign c4_in[r]  = sat_coord(SUM_W'(ta3_ff[r]) + SUM_W'(tb3_ff[r]) +
                                   SUM_W'(tr3_ff[r]));
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= v1_in;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (en1) begin
         px1_ff  <= px1_in;
         py1_ff  <= py1_in;
         val1_ff <= req_chan.pixel_value;
      end
      if (en2) begin
         for (int r = 0; r < NUM_ROWS; r++) begin
            ah2_ff[r] <= ah2_in[r];
            al2_ff[r] <= al2_in[r];
            bh2_ff[r] <= bh2_in[r];
            bl2_ff[r] <= bl2_in[r];
            tr2_ff[r] <= pose_ff[4*r+3];
         end
         val2_ff <= val1_ff;
      end
      if (en3) begin
         for (int r = 0; r < NUM_ROWS; r++) begin
            ta3_ff[r] <= ta3_in[r];
            tb3_ff[r] <= tb3_in[r];
            tr3_ff[r] <= tr2_ff[r];
         end
         val3_ff <= val2_ff;
      end
      if (en4) begin
         pt4_ff.cx    <= c4_in[0];
         pt4_ff.cy    <= c4_in[1];
         pt4_ff.cz    <= c4_in[2];
         pt4_ff.value <= val3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_point = pt4_ff;

endmodule

>>> sv/p2vb_quant.sv
// Two-stage scaling by reciprocal voxel spacing, rounding and volume bounds check.
module p2vb_quant
   import p2vb_pkg::*;
#(
   parameter int MAX_VOL_DIM = MAX_VOL_DIM_DEF
)
(
   input  logic                             clock,
   input  logic                             reset,
   input  p2vb_cfg_type                     cfg,
   input  logic [$clog2(MAX_VOL_DIM+1)-1:0] dim_x,
   input  logic [$clog2(MAX_VOL_DIM+1)-1:0] dim_y,
   input  logic [$clog2(MAX_VOL_DIM+1)-1:0] dim_z,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  p2vb_point_type                   in_point,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [$clog2(MAX_VOL_DIM)-1:0]   vox_x,
   output logic [$clog2(MAX_VOL_DIM)-1:0]   vox_y,
   output logic [$clog2(MAX_VOL_DIM)-1:0]   vox_z,
   output logic [VALUE_W-1:0]               vox_value
);

   localparam int CW  = $clog2(MAX_VOL_DIM);
   localparam int DW  = $clog2(MAX_VOL_DIM + 1);
   localparam int WHI = W_W - Q_FRAC;
   // Smallest scaled value that still truncates to voxel zero
   localparam logic signed [W_W-1:0] W_FLOOR = W_W'(1) - (W_W'(1) <<< Q_FRAC);

   logic en5, en6;

   logic signed [COORD_W-1:0] c_sel   [NUM_AXES];
   logic [SPACE_W-1:0]        r_sel   [NUM_AXES];
   logic [DW-1:0]             d_sel   [NUM_AXES];

   // Stage 5: integer and fraction parts times reciprocal
   logic                     v5_ff;
   logic signed [RHP_W-1:0]  hr5_ff [NUM_AXES], hr5_in [NUM_AXES];
   logic [RLP_W-1:0]         lr5_ff [NUM_AXES], lr5_in [NUM_AXES];
   logic [VALUE_W-1:0]       val5_ff;

   // Stage 6: rounded voxel coordinate and bounds
   logic signed [W_W-1:0]    w_val  [NUM_AXES];
   logic                     ok     [NUM_AXES];
   logic [CW-1:0]            crd_in [NUM_AXES];
   logic [CW-1:0]            crd6_ff [NUM_AXES];
   logic                     v6_ff, v6_in;
   logic [VALUE_W-1:0]       val6_ff;

   assign en6      = !v6_ff || out_ready;
   assign en5      = !v5_ff || en6;
   assign in_ready = en5;

   assign c_sel[0] = in_point.cx;
   assign c_sel[1] = in_point.cy;
   assign c_sel[2] = in_point.cz;
   assign r_sel[0] = cfg.out_recip_x;
   assign r_sel[1] = cfg.out_recip_y;
   assign r_sel[2] = cfg.out_recip_z;
   assign d_sel[0] = dim_x;
   assign d_sel[1] = dim_y;
   assign d_sel[2] = dim_z;

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      // floor(c / 2^16) * r and (c mod 2^16) * r
      assign hr5_in[a] = RHP_W'($signed(c_sel[a][COORD_W-1:Q_FRAC])) *
                         RHP_W'($signed({1'b0, r_sel[a]}));
      assign lr5_in[a] = RLP_W'(c_sel[a][Q_FRAC-1:0]) * RLP_W'(r_sel[a]);

      // add one half, then truncate toward zero; a zero-size axis takes nothing
      assign w_val[a]  = W_W'(hr5_ff[a]) +
                         W_W'($signed({1'b0, lr5_ff[a][RLP_W-1:Q_FRAC]})) +
                         W_W'(HALF_Q16);
      assign ok[a]     = w_val[a][W_W-1] ?
                         ((w_val[a] >= W_FLOOR) && (d_sel[a] != '0)) :
                         (w_val[a][W_W-1:Q_FRAC] < WHI'(d_sel[a]));
      assign crd_in[a] = w_val[a][W_W-1] ? '0 : w_val[a][Q_FRAC+CW-1:Q_FRAC];
   end

   assign v6_in = v5_ff && ok[0] && ok[1] && ok[2];

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (en5) v5_ff <= in_valid;
         if (en6) v6_ff <= v6_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (en5) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            hr5_ff[a] <= hr5_in[a];
            lr5_ff[a] <= lr5_in[a];
         end
         val5_ff <= in_point.value;
      end
      if (en6) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            crd6_ff[a] <= crd_in[a];
         end
         val6_ff <= val5_ff;
      end
   end

   assign out_valid = v6_ff;
   assign vox_x     = crd6_ff[0];
   assign vox_y     = crd6_ff[1];
   assign vox_z     = crd6_ff[2];
   assign vox_value = val6_ff;

endmodule

>>> sv/p2vb_index.sv
// Two-stage linear voxel address build; the last stage is the result register.
module p2vb_index
   import p2vb_pkg::*;
#(
   parameter int MAX_VOL_DIM = MAX_VOL_DIM_DEF
)
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic [$clog2(MAX_VOL_DIM+1)-1:0] dim_x,
   input  logic [$clog2(MAX_VOL_DIM+1)-1:0] dim_y,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [$clog2(MAX_VOL_DIM)-1:0]   vox_x,
   input  logic [$clog2(MAX_VOL_DIM)-1:0]   vox_y,
   input  logic [$clog2(MAX_VOL_DIM)-1:0]   vox_z,
   input  logic [VALUE_W-1:0]               vox_value,
   p2vb_rsp_if.source                       rsp_chan
);

   localparam int CW     = $clog2(MAX_VOL_DIM);
   localparam int DW     = $clog2(MAX_VOL_DIM + 1);
   localparam int PROD_W = (CW + 2 * DW > IDX_W) ? CW + 2 * DW : IDX_W;

   logic en7, en8;

   // Slice size, follows the dimension registers
   logic [2*DW-1:0]   dxy_ff, dxy_in;

   // Stage 7: row and slice offsets
   logic              v7_ff;
   logic [CW-1:0]     vx7_ff;
   logic [PROD_W-1:0] py7_ff, py7_in, pz7_ff, pz7_in;
   logic [VALUE_W-1:0] val7_ff;

   // Stage 8: result beat
   logic              v8_ff;
   logic [IDX_W-1:0]  idx8_ff, idx8_in;
   logic [VALUE_W-1:0] val8_ff;

   assign en8      = !v8_ff || rsp_chan.ready;
   assign en7      = !v7_ff || en8;
   assign in_ready = en7;

   assign dxy_in  = (2*DW)'(dim_x) * (2*DW)'(dim_y);
   assign py7_in  = PROD_W'(vox_y) * PROD_W'(dim_x);
   assign pz7_in  = PROD_W'(vox_z) * PROD_W'(dxy_ff);
   assign idx8_in = IDX_W'(PROD_W'(vx7_ff) + py7_ff + pz7_ff);

   always_ff @(posedge clock) begin
      dxy_ff <= dxy_in;
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else begin
         if (en7) v7_ff <= in_valid;
         if (en8) v8_ff <= v7_ff;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (en7) begin
         vx7_ff  <= vox_x;
         py7_ff  <= py7_in;
         pz7_ff  <= pz7_in;
         val7_ff <= vox_value;
      end
      if (en8) begin
         idx8_ff <= idx8_in;
         val8_ff <= val7_ff;
      end
   end

   assign rsp_chan.valid       = v8_ff;
   assign rsp_chan.voxel_index = idx8_ff;
   assign rsp_chan.voxel_value = val8_ff;

endmodule

>>> sv/pixel_to_voxel_binning.sv
// Pixel-to-voxel binning: maps ultrasound pixels through a pose into a voxel volume.
//
// Usage:
//   req_chan carries load beats (op = 0, one pose coefficient, signed Q16.16,
//   row-major 3x4) and pixel beats (op = 1: beam, sample, value, mask bit).
//   rsp_chan carries one beat per pixel that is masked in, inside the frame
//   and lands inside the volume: the linear voxel index and the pixel value.
//   Loads, masked-out pixels and misses give no beat.
//   The csr_ port writes spacing, reciprocal spacing and volume size; write
//   it only while the pipeline is empty.
// Timing:
//   Eight register stages (one point scale, three pose multiply/sum, two
//   reciprocal scale/round, two index build), passed in order before a pixel's
//   beat shows on rsp_chan. One beat per cycle is taken while the receiver
//   keeps up; a load takes effect for the very next pixel.
// Reset: synchronous; clears the pose to zero, registers to their defaults
//   (unit spacing, 256^3 volume) and empties the pipeline.
// Stall: each stage holds only while the stage after it is full and stalled,
//   so empty stages keep filling while rsp_chan.ready is low.
module pixel_to_voxel_binning
   import p2vb_pkg::*;
#(
   parameter int MAX_VOL_DIM = MAX_VOL_DIM_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   p2vb_req_if.sink              req_chan,
   p2vb_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW = $clog2(MAX_VOL_DIM);
   localparam int DW = $clog2(MAX_VOL_DIM + 1);

   p2vb_cfg_type   cfg_ff, cfg_in;
   logic [DW-1:0]  dim_x, dim_y, dim_z;

   logic           x_valid, x_ready;
   p2vb_point_type x_point;
   logic           q_valid, q_ready;
   logic [CW-1:0]  vox_x, vox_y, vox_z;
   logic [VALUE_W-1:0] vox_value;

   function automatic logic [DW-1:0] clamp_dim(input logic [DIM_REG_W-1:0] d);
      if (32'(d) > MAX_VOL_DIM) begin
         return DW'(MAX_VOL_DIM);
      end
      return DW'(d);
   endfunction

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_IN_SPACING_X: cfg_in.in_spacing_x = csr_wdata;
            CSR_IN_SPACING_Y: cfg_in.in_spacing_y = csr_wdata;
            CSR_OUT_RECIP_X:  cfg_in.out_recip_x  = csr_wdata;
            CSR_OUT_RECIP_Y:  cfg_in.out_recip_y  = csr_wdata;
            CSR_OUT_RECIP_Z:  cfg_in.out_recip_z  = csr_wdata;
            CSR_VOL_DIM_X:    cfg_in.vol_dim_x    = csr_wdata[DIM_REG_W-1:0];
            CSR_VOL_DIM_Y:    cfg_in.vol_dim_y    = csr_wdata[DIM_REG_W-1:0];
            CSR_VOL_DIM_Z:    cfg_in.vol_dim_z    = csr_wdata[DIM_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Oversized dimensions clip to the largest supported volume
   assign dim_x = clamp_dim(cfg_ff.vol_dim_x);
   assign dim_y = clamp_dim(cfg_ff.vol_dim_y);
   assign dim_z = clamp_dim(cfg_ff.vol_dim_z);

   p2vb_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_chan  (req_chan),
      .out_valid (x_valid),
      .out_ready (x_ready),
      .out_point (x_point)
   );

   p2vb_quant #(
      .MAX_VOL_DIM (MAX_VOL_DIM)
   ) u_quant (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .dim_x     (dim_x),
      .dim_y     (dim_y),
      .dim_z     (dim_z),
      .in_valid  (x_valid),
      .in_ready  (x_ready),
      .in_point  (x_point),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .vox_x     (vox_x),
      .vox_y     (vox_y),
      .vox_z     (vox_z),
      .vox_value (vox_value)
   );

   p2vb_index #(
      .MAX_VOL_DIM (MAX_VOL_DIM)
   ) u_index (
      .clock     (clock),
      .reset     (reset),
      .dim_x     (dim_x),
      .dim_y     (dim_y),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .vox_x     (vox_x),
      .vox_y     (vox_y),
      .vox_z     (vox_z),
      .vox_value (vox_value),
      .rsp_chan  (rsp_chan)
   );

`ifndef SYNTHESIS
   // A ready receiver opens the whole pipeline
   a_ready_flow: assert property (@(posedge clock)
      rsp_chan.ready |-> req_chan.ready)
      else $error("input blocked while result side is ready");

   // Reset empties the result stage
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result beat pending after reset");

   // Every voxel that reaches address build lies inside the volume
   a_vox_range: assert property (@(posedge clock) disable iff (reset)
      q_valid |-> (DW'(vox_x) < dim_x) && (DW'(vox_y) < dim_y) && (DW'(vox_z) < dim_z))
      else $error("voxel coordinate outside volume");
`endif

endmodule
